### rtl/core/srt_pkg.sv
// Shared types and constants of the share reservation table.
package srt_pkg;
   localparam int TableEntries = 64;
   localparam int IdxW = $clog2(TableEntries);
   localparam int EntryW = 64 + 16 + 32 + 2 + 2;

   typedef enum logic [1:0] {
      REQ_SHARE   = 2'd0,
      REQ_UNSHARE = 2'd1,
      REQ_PURGE   = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_GRANTED = 2'd0,
      ST_CONFLICT = 2'd1,
      ST_GRACE   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // command handed from the front part to the back part
   typedef struct packed {
      req_kind_type kind;
      logic [63:0]  file_key;
      logic [15:0]  client_id;
      logic [31:0]  owner_id;
      logic [1:0]   share_mode;
      logic [1:0]   share_access;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_LAST,
      BK_DONE
   } back_state_type;
endpackage

### rtl/core/srt_ram.sv
// Generic single-port RAM with registered read.
module srt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### rtl/core/srt_front.sv
// Front part: accepts requests, applies the grace period, queues commands.
module srt_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_type,
   input  logic [63:0]            req_file_key,
   input  logic [15:0]            req_client_id,
   input  logic [31:0]            req_owner_id,
   input  logic [1:0]             req_share_mode,
   input  logic [1:0]             req_share_access,
   input  logic                   req_reclaim,
   input  logic                   grace_active,
   output logic                   cmd_valid,
   output srt_pkg::cmd_type       cmd,
   input  logic                   cmd_taken,
   input  logic                   back_busy,
   output logic                   fast_valid,
   output srt_pkg::status_type    fast_status
);
   import srt_pkg::*;

   logic    q_valid_ff, q_valid_in;
   cmd_type q_ff, q_in;
   logic    fast_valid_ff, fast_valid_in;
   status_type fast_status_ff, fast_status_in;
   logic    acc;
   logic    pend_ff, pend_in;

   // one item in flight from acceptance until its result has left
   assign busy = pend_ff;
   assign acc  = start && !busy;

   always_comb begin
      q_valid_in     = q_valid_ff && !cmd_taken;
      q_in           = q_ff;
      fast_valid_in  = 1'b0;
      fast_status_in = ST_GRANTED;
      pend_in        = pend_ff;
      if (fast_valid_ff || (pend_ff && !q_valid_ff && !back_busy && !cmd_taken)) begin
         pend_in = 1'b0;
      end
      if (acc) begin
         pend_in = 1'b1;
         unique case (req_kind_type'(req_type))
            REQ_NONE: begin
               fast_valid_in = 1'b1;
            end
            REQ_SHARE, REQ_UNSHARE: begin
               if (grace_active && !req_reclaim) begin
                  fast_valid_in  = 1'b1;
                  fast_status_in = ST_GRACE;
               end else begin
                  q_valid_in = 1'b1;
               end
            end
            default: q_valid_in = 1'b1;
         endcase
         q_in.kind         = req_kind_type'(req_type);
         q_in.file_key     = req_file_key;
         q_in.client_id    = req_client_id;
         q_in.owner_id     = req_owner_id;
         q_in.share_mode   = req_share_mode;
         q_in.share_access = req_share_access;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff    <= 1'b0;
         fast_valid_ff <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         q_valid_ff    <= q_valid_in;
         fast_valid_ff <= fast_valid_in;
         pend_ff       <= pend_in;
      end
      q_ff           <= q_in;
      fast_status_ff <= fast_status_in;
   end

   assign cmd_valid   = q_valid_ff;
   assign cmd         = q_ff;
   assign fast_valid  = fast_valid_ff;
   assign fast_status = fast_status_ff;
endmodule

### rtl/core/srt_back.sv
// Back part: scans the table and carries out share, unshare and purge.
module srt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  srt_pkg::cmd_type    cmd,
   output logic                cmd_taken,
   output logic                back_busy,
   output logic                done_valid,
   output srt_pkg::status_type done_status
);
   import srt_pkg::*;

   back_state_type state_ff, state_in;
   cmd_type        c_ff, c_in;
   logic [TableEntries-1:0] valid_ff, valid_in;
   logic [IdxW-1:0] idx_ff, idx_in;      // read address
   logic [IdxW-1:0] chk_ff, chk_in;      // slot whose data is on rd_data
   logic            exact_ff, exact_in;
   logic            conf_ff, conf_in;
   logic            free_ff, free_in;
   logic [IdxW-1:0] free_idx_ff, free_idx_in;
   logic [IdxW-1:0] hit_idx_ff, hit_idx_in;
   logic            dv_ff, dv_in;
   status_type      ds_ff, ds_in;
   logic            wr_en;
   logic [IdxW-1:0] ram_addr;
   logic [EntryW-1:0] wr_data, rd_data;
   logic [63:0] e_file;
   logic [15:0] e_client;
   logic [31:0] e_owner;
   logic [1:0]  e_mode, e_acc;
   logic        e_live;

   assign {e_file, e_client, e_owner, e_mode, e_acc} = rd_data;
   assign wr_data = {c_ff.file_key, c_ff.client_id, c_ff.owner_id,
                     c_ff.share_mode, c_ff.share_access};

   srt_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (ram_addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      c_in        = c_ff;
      valid_in    = valid_ff;
      idx_in      = idx_ff;
      chk_in      = chk_ff;
      exact_in    = exact_ff;
      conf_in     = conf_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      hit_idx_in  = hit_idx_ff;
      dv_in       = 1'b0;
      ds_in       = ST_GRANTED;
      cmd_taken   = 1'b0;
      wr_en       = 1'b0;
      ram_addr    = idx_ff;
      e_live      = valid_ff[chk_ff];
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_taken = 1'b1;
               c_in      = cmd;
               idx_in    = IdxW'(1);
               chk_in    = '0;
               exact_in  = 1'b0;
               conf_in   = 1'b0;
               free_in   = 1'b0;
               ram_addr  = '0;
               state_in  = BK_SCAN;
            end
         end
         BK_SCAN, BK_LAST: begin
            // examine the slot read last cycle
            if (e_live && c_ff.kind == REQ_PURGE && e_client == c_ff.client_id) begin
               valid_in[chk_ff] = 1'b0;
            end
            if (e_live && e_file == c_ff.file_key) begin
               if (e_client == c_ff.client_id && e_owner == c_ff.owner_id && !exact_in) begin
                  exact_in   = 1'b1;
                  hit_idx_in = chk_ff;
               end
               if ((e_mode & c_ff.share_access) != 2'b00 ||
                   (e_acc & c_ff.share_mode) != 2'b00) begin
                  conf_in = 1'b1;
               end
            end
            if (!valid_ff[chk_ff] && !free_in) begin
               free_in     = 1'b1;
               free_idx_in = chk_ff;
            end
            chk_in = idx_ff;
            idx_in = idx_ff + IdxW'(1);
            if (state_ff == BK_LAST) begin
               state_in = BK_DONE;
            end else if (idx_ff == IdxW'(TableEntries - 1)) begin
               state_in = BK_LAST;
            end
         end
         BK_DONE: begin
            dv_in    = 1'b1;
            state_in = BK_IDLE;
            priority case (1'b1)
               c_ff.kind == REQ_UNSHARE: begin
                  if (exact_ff) valid_in[hit_idx_ff] = 1'b0;
               end
               c_ff.kind == REQ_SHARE && !exact_ff: begin
                  if (conf_ff) begin
                     ds_in = ST_CONFLICT;
                  end else if (!free_ff) begin
                     ds_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     ram_addr = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= '0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         dv_ff    <= dv_in;
      end
      c_ff        <= c_in;
      idx_ff      <= idx_in;
      chk_ff      <= chk_in;
      exact_ff    <= exact_in;
      conf_ff     <= conf_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      hit_idx_ff  <= hit_idx_in;
      ds_ff       <= ds_in;
   end

   assign back_busy   = (state_ff != BK_IDLE) || dv_ff;
   assign done_valid  = dv_ff;
   assign done_status = ds_ff;
endmodule

### rtl/core/share_reservation_table.sv
// Top level of the share reservation table.
// Usage: drive the request ports and pulse start while busy is low; the
// item is taken at that edge. busy stays high until its result has left.
// One result per item appears on rsp_status for exactly one cycle, marked
// by rsp_valid; the receiver cannot stall it.
// A share or unshare refused by the grace period, or an unused request
// type, is answered in the cycle after acceptance and busy drops with the
// end of that cycle. Every other item is queued by the front part, taken
// by the back part and runs a scan of all table slots through the single
// port of the entry memory, then a done state that sets the registered
// result; busy stays high past the result until the back part is idle.
// The grace_active register is written over csr_valid/csr_ready; ready is
// always high and writes are expected only while idle.
// Reset clears all slot valid bits, the register, state and valid flags.
module share_reservation_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_file_key,
   input  logic [15:0] req_client_id,
   input  logic [31:0] req_owner_id,
   input  logic [1:0]  req_share_mode,
   input  logic [1:0]  req_share_access,
   input  logic        req_reclaim,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_grace_active
);
   import srt_pkg::*;

   logic       grace_ff;
   logic       cmd_valid, cmd_taken, back_busy;
   cmd_type    cmd;
   logic       fast_valid, done_valid;
   status_type fast_status, done_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff <= 1'b0;
      end else if (csr_valid) begin
         grace_ff <= csr_grace_active;
      end
   end

   srt_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_file_key(req_file_key),
      .req_client_id(req_client_id), .req_owner_id(req_owner_id),
      .req_share_mode(req_share_mode), .req_share_access(req_share_access),
      .req_reclaim(req_reclaim), .grace_active(grace_ff),
      .cmd_valid(cmd_valid), .cmd(cmd), .cmd_taken(cmd_taken),
      .back_busy(back_busy), .fast_valid(fast_valid), .fast_status(fast_status)
   );

   srt_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_taken(cmd_taken), .back_busy(back_busy),
      .done_valid(done_valid), .done_status(done_status)
   );

   assign rsp_valid  = fast_valid || done_valid;
   assign rsp_status = fast_valid ? fast_status : done_status;
endmodule
